// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the ID table core.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at this edge whenever the trigger does.
`define ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed: same-cycle implication");

// The condition holds at the next edge whenever the trigger does.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, trig, cond)
`define ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

// ----- rtl/itss_pkg.sv -----
// Package of the ID table core: field widths, request and status codes, structs.
// Depends on nothing; the interfaces, the sequencer and the top level import it.
`default_nettype none

package itss_pkg;

   localparam int ITSS_DEPTH = 256;
   localparam int ID_W       = 31;
   localparam int POS_W      = 8;
   localparam int TYPE_W     = 3;
   localparam int STAT_W     = 3;
   localparam int SIZE_W     = 9;

   localparam logic [ID_W-1:0]   EMPTY_ID        = 31'h7FFF_FFFF;
   localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 9'd256;

   localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_SORT   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_LSRCH  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_BSRCH  = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_READ   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP       = 3'd1;
   localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd4;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  found_pos;
      logic [ID_W-1:0]   entry_value;
   } res_type;

   typedef struct packed {
      logic req_ready;
      logic cfg_ready;
      logic done;
   } seq_stat_type;

endpackage

`default_nettype wire

// ----- rtl/itss_if.sv -----
// Valid/ready channel interfaces of the ID table core: request, response, register write.
// Depends on itss_pkg for the field widths.
`default_nettype none

interface itss_req_if import itss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [ID_W-1:0]   book_id;
   logic [POS_W-1:0]  slot_pos;
   logic              descending;
   modport source (output valid, req_type, book_id, slot_pos, descending, input ready);
   modport sink   (input valid, req_type, book_id, slot_pos, descending, output ready);
endinterface

interface itss_rsp_if import itss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [POS_W-1:0]  found_pos;
   logic [ID_W-1:0]   entry_value;
   modport source (output valid, status, found_pos, entry_value, input ready);
   modport sink   (input valid, status, found_pos, entry_value, output ready);
endinterface

interface itss_csr_if import itss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] active_size;
   modport source (output valid, active_size, input ready);
   modport sink   (input valid, active_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/itss_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module itss_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/itss_seq.sv -----
// Sequencer of the ID table core: walks the table memory for every request.
// Depends on itss_pkg; drives the ports of one itss_ram.
`default_nettype none

module itss_seq import itss_pkg::*; #(
   parameter int DEPTH = ITSS_DEPTH,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CW-1:0]     size_n,
   input  wire logic              clr_start,
   input  wire logic [CW-1:0]     clr_from,
   input  wire logic [CW-1:0]     clr_upto,
   input  wire logic              req_valid,
   input  wire logic [TYPE_W-1:0] req_type,
   input  wire logic [ID_W-1:0]   book_id,
   input  wire logic [POS_W-1:0]  slot_pos,
   input  wire logic              descending,
   input  wire logic              out_free,
   output      seq_stat_type      stat,
   output      res_type           result,
   output      logic              mem_we,
   output      logic [AW-1:0]     mem_waddr,
   output      logic [ID_W-1:0]   mem_wdata,
   output      logic [AW-1:0]     mem_raddr,
   input  wire logic [ID_W-1:0]   mem_rdata
);

   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_INS_MV, S_INS_WR,
      S_BIN_STEP, S_BIN_CHK, S_BIN_LO, S_BIN_HI, S_RD_DATA,
      S_SORT_KEY, S_SORT_KEYD, S_SORT_CMP, S_SORT_PUT, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic              boot_ff, boot_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     end_ff, end_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [ID_W-1:0]   key_ff, key_in;
   logic [TYPE_W-1:0] op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              desc_ff, desc_in;
   res_type           rslt_ff, rslt_in;

   logic [PW-1:0]     pos_wide;
   logic [PW-1:0]     n_wide;
   logic              bad_id;
   logic [CW:0]       mid_sum;
   logic              sort_move;

   function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
      logic [PW-1:0] w;
      w = PW'(v);
      return w[POS_W-1:0];
   endfunction

   function automatic res_type mk_res(input logic [STAT_W-1:0] st,
                                      input logic [POS_W-1:0] p,
                                      input logic [ID_W-1:0] v);
      res_type r;
      r.status      = st;
      r.found_pos   = p;
      r.entry_value = v;
      return r;
   endfunction

   assign pos_wide  = PW'(slot_pos);
   assign n_wide    = PW'(size_n);
   assign bad_id    = (book_id == '0) || (book_id == EMPTY_ID);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign sort_move = desc_ff ? (mem_rdata < key_ff) : (mem_rdata > key_ff);

   always_comb begin
      state_in  = state_ff;
      boot_in   = boot_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      fill_in   = fill_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      key_in    = key_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      pos_in    = pos_ff;
      desc_in   = desc_ff;
      rslt_in   = rslt_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = EMPTY_ID;
      mem_raddr = idx_ff[AW-1:0];
      stat.req_ready = (state_ff == S_IDLE) && !clr_start;
      stat.cfg_ready = (state_ff == S_IDLE) || boot_ff;
      stat.done      = (state_ff == S_DONE) && out_free;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == end_ff) begin
               state_in = S_IDLE;
               boot_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (clr_start) begin
               idx_in   = clr_from;
               end_in   = clr_upto;
               state_in = S_CLEAR;
            end else if (req_valid) begin
               op_in   = req_type;
               id_in   = book_id;
               pos_in  = pos_wide;
               desc_in = descending;
               idx_in  = '0;
               case (req_type)
                  REQ_APPEND, REQ_INSERT, REQ_LSRCH: begin
                     if (bad_id) begin
                        rslt_in  = mk_res(ST_BAD_ID, '0, '0);
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  REQ_SORT: begin
                     i_in = CW'(1);
                     if (size_n < CW'(2)) begin
                        rslt_in  = mk_res(ST_OK, '0, '0);
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SORT_KEY;
                     end
                  end
                  REQ_BSRCH: begin
                     lo_in = '0;
                     hi_in = size_n - 1'b1;
                     if (bad_id) begin
                        rslt_in  = mk_res(ST_BAD_ID, '0, '0);
                        state_in = S_DONE;
                     end else begin
                        state_in = S_BIN_STEP;
                     end
                  end
                  REQ_READ: begin
                     mem_raddr = pos_wide[AW-1:0];
                     if (pos_wide >= n_wide) begin
                        rslt_in  = mk_res(ST_RANGE, '0, '0);
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RD_DATA;
                     end
                  end
                  default: begin
                     rslt_in  = mk_res(ST_RANGE, '0, '0);
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (mem_rdata == id_ff) begin
               if (op_ff == REQ_LSRCH) begin
                  rslt_in = mk_res(ST_OK, to_pos(idx_ff), id_ff);
               end else begin
                  rslt_in = mk_res(ST_DUP, '0, '0);
               end
               state_in = S_DONE;
            end else if (idx_ff + 1'b1 != size_n) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else if (op_ff == REQ_LSRCH) begin
               rslt_in  = mk_res(ST_NOT_FOUND, '0, '0);
               state_in = S_DONE;
            end else if (fill_ff >= size_n ||
                         (op_ff == REQ_INSERT && pos_ff >= n_wide)) begin
               rslt_in  = mk_res(ST_RANGE, '0, '0);
               state_in = S_DONE;
            end else if (op_ff == REQ_APPEND) begin
               mem_we    = 1'b1;
               mem_waddr = fill_ff[AW-1:0];
               mem_wdata = id_ff;
               fill_in   = fill_ff + 1'b1;
               rslt_in   = mk_res(ST_OK, to_pos(fill_ff), id_ff);
               state_in  = S_DONE;
            end else begin
               mem_raddr = pos_ff[AW-1:0];
               state_in  = S_INS_MV;
            end
         end
         S_INS_MV: begin
            // The displaced entry moves to the fill point before the new ID lands.
            mem_we    = 1'b1;
            mem_waddr = fill_ff[AW-1:0];
            mem_wdata = mem_rdata;
            state_in  = S_INS_WR;
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = id_ff;
            fill_in   = fill_ff + 1'b1;
            rslt_in   = mk_res(ST_OK, pos_ff[POS_W-1:0], id_ff);
            state_in  = S_DONE;
         end
         S_BIN_STEP: begin
            if (hi_ff > lo_ff && hi_ff - lo_ff > CW'(1)) begin
               mid_in    = mid_sum[CW:1];
               mem_raddr = mid_sum[AW:1];
               state_in  = S_BIN_CHK;
            end else begin
               mem_raddr = lo_ff[AW-1:0];
               state_in  = S_BIN_LO;
            end
         end
         S_BIN_CHK: begin
            if (mem_rdata < id_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_BIN_STEP;
         end
         S_BIN_LO: begin
            mem_raddr = hi_ff[AW-1:0];
            if (mem_rdata == id_ff) begin
               rslt_in  = mk_res(ST_OK, to_pos(lo_ff), id_ff);
               state_in = S_DONE;
            end else begin
               state_in = S_BIN_HI;
            end
         end
         S_BIN_HI: begin
            if (mem_rdata == id_ff) begin
               rslt_in = mk_res(ST_OK, to_pos(hi_ff), id_ff);
            end else begin
               rslt_in = mk_res(ST_NOT_FOUND, '0, '0);
            end
            state_in = S_DONE;
         end
         S_RD_DATA: begin
            rslt_in  = mk_res(ST_OK, pos_ff[POS_W-1:0], mem_rdata);
            state_in = S_DONE;
         end
         S_SORT_KEY: begin
            mem_raddr = i_ff[AW-1:0];
            state_in  = S_SORT_KEYD;
         end
         S_SORT_KEYD: begin
            key_in    = mem_rdata;
            j_in      = i_ff;
            mem_raddr = AW'(i_ff - 1'b1);
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            if (sort_move) begin
               mem_wdata = mem_rdata;
               j_in      = j_ff - 1'b1;
               mem_raddr = AW'(j_ff - CW'(2));
               if (j_ff == CW'(1)) begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               mem_wdata = key_ff;
               i_in      = i_ff + 1'b1;
               if (i_ff + 1'b1 == size_n) begin
                  rslt_in  = mk_res(ST_OK, '0, '0);
                  state_in = S_DONE;
               end else begin
                  state_in = S_SORT_KEY;
               end
            end
         end
         S_SORT_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            mem_wdata = key_ff;
            i_in      = i_ff + 1'b1;
            if (i_ff + 1'b1 == size_n) begin
               rslt_in  = mk_res(ST_OK, '0, '0);
               state_in = S_DONE;
            end else begin
               state_in = S_SORT_KEY;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result = rslt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         boot_ff  <= 1'b1;
         idx_ff   <= '0;
         end_ff   <= CW'(DEPTH);
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
         idx_ff   <= idx_in;
         end_ff   <= end_in;
         fill_ff  <= fill_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      key_ff  <= key_in;
      op_ff   <= op_in;
      id_ff   <= id_in;
      pos_ff  <= pos_in;
      desc_ff <= desc_in;
      rslt_ff <= rslt_in;
   end

endmodule

`default_nettype wire

// ----- rtl/id_table_insert_sort_search_core.sv -----
// Top level of the ID table core: size register, response register, sequencer and table RAM.
// Depends on itss_pkg, itss_if.sv, itss_ram, itss_seq and assert_macros.svh.
//
// The core keeps a table of unique positive 31-bit IDs in one RAM of DEPTH words.
// Requests arrive on req_chan, one transfer per request; each request gives exactly
// one transfer on rsp_chan. The csr_chan transfer writes active_size, the number of
// slots in use; growing it fills the newly exposed slots with the empty marker.
// A request is handled one at a time. Every RAM read returns registered data, so a
// search or duplicate check visits each slot in a read state and a check state, a
// binary search halves the range with a read per step, and a sort is an insertion
// sort run in the RAM. After reset the core sweeps the whole RAM with the empty
// marker and takes no request until it ends; size writes are accepted meanwhile.
// Growing the size sweeps the new slots in the same way, one per cycle.
// The response sits in an output register, so a stalled receiver holds it there
// while the core finishes the next request and then waits for the register to free.
`default_nettype none
`include "assert_macros.svh"

module id_table_insert_sort_search_core import itss_pkg::*; #(
   parameter int DEPTH = ITSS_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   itss_req_if.sink   req_chan,
   itss_rsp_if.source rsp_chan,
   itss_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [SIZE_W-1:0] size_ff;
   logic              rsp_valid_ff;
   res_type           rsp_ff;

   logic [CW-1:0]     size_now;
   logic [CW-1:0]     size_new;
   logic              csr_hit;
   logic              clr_start;
   logic              out_free;
   seq_stat_type      seq_stat;
   res_type           seq_res;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [ID_W-1:0]   mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [ID_W-1:0]   mem_rdata;

   // The effective size is the register clamped to one slot at least and DEPTH at most.
   function automatic logic [CW-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
      logic [31:0] w;
      w = 32'(raw);
      if (w == 32'd0) begin
         w = 32'd1;
      end else if (w > 32'(DEPTH)) begin
         w = 32'(DEPTH);
      end
      return w[CW-1:0];
   endfunction

   assign size_now  = clamp_size(size_ff);
   assign size_new  = clamp_size(csr_chan.active_size);
   assign csr_hit   = csr_chan.valid && csr_chan.ready;
   assign clr_start = csr_hit && (size_new > size_now);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign csr_chan.ready = seq_stat.cfg_ready;
   assign req_chan.ready = seq_stat.req_ready;

   itss_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .size_n     (size_now),
      .clr_start  (clr_start),
      .clr_from   (size_now),
      .clr_upto   (size_new),
      .req_valid  (req_chan.valid),
      .req_type   (req_chan.req_type),
      .book_id    (req_chan.book_id),
      .slot_pos   (req_chan.slot_pos),
      .descending (req_chan.descending),
      .out_free   (out_free),
      .stat       (seq_stat),
      .result     (seq_res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   itss_ram #(
      .WIDTH (ID_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Size register, and the response register that decouples the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= ACTIVE_SIZE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_hit) begin
            size_ff <= csr_chan.active_size;
         end
         if (seq_stat.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (seq_stat.done) begin
         rsp_ff <= seq_res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.found_pos   = rsp_ff.found_pos;
   assign rsp_chan.entry_value = rsp_ff.entry_value;

   // A finished result is only handed over when the response register can take it.
   `ASSERT_IMPLY(a_done_into_free, clock, reset, seq_stat.done, out_free)
   // Requests are only taken while size writes are also possible, that is when idle.
   `ASSERT_IMPLY(a_req_only_idle, clock, reset, req_chan.ready, csr_chan.ready)
   // Once a request is taken the core is busy for at least the next cycle.
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_chan.valid && req_chan.ready,
                !req_chan.ready)

endmodule

`default_nettype wire

// ----- tb/tb_itss_if.sv -----
// Testbench package of the ID table core: the struct of one pending request.
// Depends on itss_pkg for the field widths.
`timescale 1ns / 100ps

package tb_itss_types;
   import itss_pkg::*;
   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [ID_W-1:0]   book_id;
      logic [POS_W-1:0]  slot_pos;
      logic              descending;
   } tb_req_t;
endpackage

// ----- tb/tb.sv -----
// Self-checking testbench of id_table_insert_sort_search_core.
// Depends on itss_pkg, tb_itss_types, the RTL channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb;
   import itss_pkg::*;
   import tb_itss_types::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   itss_req_if req_chan ();
   itss_rsp_if rsp_chan ();
   itss_csr_if csr_chan ();

   id_table_insert_sort_search_core uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   // Predictor state: its own copy of the table, fill count and size register.
   logic [ID_W-1:0]   table_mirror [ITSS_DEPTH];
   int unsigned       mirror_fill;
   logic [SIZE_W-1:0] mirror_size;

   tb_req_t pending_reqs[$];
   res_type expected_rsps[$];
   int      error_count = 0;
   int      gap_left = 0;
   int      burst_left = 0;
   int      stall_phase = 0;
   bit      stim_done = 0;

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw);
      if (raw < 1) return 1;
      if (raw > ITSS_DEPTH) return ITSS_DEPTH;
      return raw;
   endfunction

   function automatic res_type make_rsp(logic [STAT_W-1:0] st, int unsigned pos,
                                        logic [ID_W-1:0] val);
      res_type r;
      r.status = st;
      r.found_pos = pos[POS_W-1:0];
      r.entry_value = val;
      return r;
   endfunction

   function automatic void mirror_resize(logic [SIZE_W-1:0] raw);
      int unsigned old_n, new_n;
      old_n = clamp_size(mirror_size);
      mirror_size = raw;
      new_n = clamp_size(raw);
      for (int unsigned i = old_n; i < new_n; i++) table_mirror[i] = EMPTY_ID;
   endfunction

   // Works out the single response that one request causes, updating the mirror.
   function automatic res_type table_outcome(tb_req_t rq);
      int unsigned n, lo, hi, mid;
      logic [ID_W-1:0] key;
      bit bad, dup;
      int j;
      n = clamp_size(mirror_size);
      bad = (rq.book_id == 0) || (rq.book_id == EMPTY_ID);
      dup = 0;
      for (int unsigned i = 0; i < n; i++) if (table_mirror[i] == rq.book_id) dup = 1;
      case (rq.req_type)
         REQ_APPEND, REQ_INSERT: begin
            if (bad) return make_rsp(ST_BAD_ID, 0, 0);
            if (dup) return make_rsp(ST_DUP, 0, 0);
            if (rq.req_type == REQ_APPEND) begin
               if (mirror_fill >= n) return make_rsp(ST_RANGE, 0, 0);
               table_mirror[mirror_fill] = rq.book_id;
               mirror_fill++;
               return make_rsp(ST_OK, mirror_fill - 1, rq.book_id);
            end
            if (rq.slot_pos >= n || mirror_fill >= n) return make_rsp(ST_RANGE, 0, 0);
            table_mirror[mirror_fill] = table_mirror[rq.slot_pos];
            table_mirror[rq.slot_pos] = rq.book_id;
            mirror_fill++;
            return make_rsp(ST_OK, rq.slot_pos, rq.book_id);
         end
         REQ_SORT: begin
            for (int unsigned i = 1; i < n; i++) begin
               key = table_mirror[i];
               j = i;
               while (j > 0 && (rq.descending ? table_mirror[j-1] < key
                                              : table_mirror[j-1] > key)) begin
                  table_mirror[j] = table_mirror[j-1];
                  j--;
               end
               table_mirror[j] = key;
            end
            return make_rsp(ST_OK, 0, 0);
         end
         REQ_LSRCH: begin
            if (bad) return make_rsp(ST_BAD_ID, 0, 0);
            for (int unsigned i = 0; i < n; i++)
               if (table_mirror[i] == rq.book_id) return make_rsp(ST_OK, i, rq.book_id);
            return make_rsp(ST_NOT_FOUND, 0, 0);
         end
         REQ_BSRCH: begin
            if (bad) return make_rsp(ST_BAD_ID, 0, 0);
            lo = 0;
            hi = n - 1;
            while (hi > lo && hi - lo > 1) begin
               mid = (hi + lo) / 2;
               if (table_mirror[mid] < rq.book_id) lo = mid + 1;
               else hi = mid;
            end
            if (table_mirror[lo] == rq.book_id) return make_rsp(ST_OK, lo, rq.book_id);
            if (table_mirror[hi] == rq.book_id) return make_rsp(ST_OK, hi, rq.book_id);
            return make_rsp(ST_NOT_FOUND, 0, 0);
         end
         REQ_READ: begin
            if (rq.slot_pos >= n) return make_rsp(ST_RANGE, 0, 0);
            return make_rsp(ST_OK, rq.slot_pos, table_mirror[rq.slot_pos]);
         end
         default: return make_rsp(ST_RANGE, 0, 0);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h", what, got, want);
      error_count++;
   endtask

   // Driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            tb_req_t rq;
            rq = pending_reqs.pop_front();
            expected_rsps.push_back(table_outcome(rq));
            req_chan.valid <= 1'b1;
            req_chan.req_type <= rq.req_type;
            req_chan.book_id <= rq.book_id;
            req_chan.slot_pos <= rq.slot_pos;
            req_chan.descending <= rq.descending;
            if (burst_left > 0) burst_left <= burst_left - 1;
            else begin
               burst_left <= $urandom_range(0, 8);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls on a fixed repeating pattern: always ready early in each period, then ready only intermittently.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 97;
         rsp_chan.ready <= (stall_phase < 40) ? 1'b1 : ((stall_phase % 7) < 3);
      end
   end

   // Monitor: each response transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_chan.status, 0);
         end else begin
            res_type e;
            e = expected_rsps.pop_front();
            if (rsp_chan.status !== e.status)
               report_mismatch("status", rsp_chan.status, e.status);
            if (rsp_chan.found_pos !== e.found_pos)
               report_mismatch("found_pos", rsp_chan.found_pos, e.found_pos);
            if (rsp_chan.entry_value !== e.entry_value)
               report_mismatch("entry_value", rsp_chan.entry_value, e.entry_value);
         end
      end
   end

   function automatic tb_req_t mk(logic [2:0] t, logic [ID_W-1:0] id, logic [7:0] p,
                                  logic d);
      tb_req_t r;
      r.req_type = t; r.book_id = id; r.slot_pos = p; r.descending = d;
      return r;
   endfunction

   // Waits until the block is idle, then writes the size register.
   task automatic write_size(logic [SIZE_W-1:0] v);
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (600) @(posedge clock);
      csr_chan.active_size <= v;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      mirror_resize(v);
      repeat (300) @(posedge clock);
   endtask

   // Random IDs come mostly from a small pool so duplicates and hits are common.
   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 0 : EMPTY_ID;
         1, 2: return $urandom() & EMPTY_ID;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   function automatic logic [2:0] pick_type();
      int k;
      k = $urandom_range(0, 99);
      if (k < 35) return REQ_APPEND;
      if (k < 50) return REQ_INSERT;
      if (k < 54) return REQ_SORT;
      if (k < 68) return REQ_LSRCH;
      if (k < 82) return REQ_BSRCH;
      if (k < 97) return REQ_READ;
      return $urandom_range(6, 7);
   endfunction

   initial begin
      logic [SIZE_W-1:0] sizes [6];
      for (int i = 0; i < ITSS_DEPTH; i++) table_mirror[i] = EMPTY_ID;
      mirror_fill = 0;
      mirror_size = ACTIVE_SIZE_RST;
      req_chan.valid = 1'b0;
      req_chan.req_type = '0;
      req_chan.book_id = '0;
      req_chan.slot_pos = '0;
      req_chan.descending = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.active_size = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a small table: extremes, every request and edge case.
      write_size(4);
      pending_reqs.push_back(mk(REQ_APPEND, 0, 0, 0));
      pending_reqs.push_back(mk(REQ_APPEND, EMPTY_ID, 0, 0));
      pending_reqs.push_back(mk(REQ_APPEND, 31'h7FFF_FFFE, 0, 0));
      pending_reqs.push_back(mk(REQ_APPEND, 1, 0, 0));
      pending_reqs.push_back(mk(REQ_APPEND, 1, 0, 0));
      pending_reqs.push_back(mk(REQ_INSERT, 5, 8'hFF, 0));
      pending_reqs.push_back(mk(REQ_INSERT, 5, 2, 0));
      pending_reqs.push_back(mk(REQ_INSERT, 9, 0, 1));
      pending_reqs.push_back(mk(REQ_APPEND, 7, 0, 0));
      pending_reqs.push_back(mk(REQ_SORT, 0, 0, 0));
      pending_reqs.push_back(mk(REQ_BSRCH, 5, 0, 0));
      pending_reqs.push_back(mk(REQ_BSRCH, 31'h7FFF_FFFE, 0, 0));
      pending_reqs.push_back(mk(REQ_BSRCH, 0, 0, 0));
      pending_reqs.push_back(mk(REQ_LSRCH, 9, 0, 0));
      pending_reqs.push_back(mk(REQ_LSRCH, 3, 0, 0));
      pending_reqs.push_back(mk(REQ_LSRCH, EMPTY_ID, 0, 0));
      pending_reqs.push_back(mk(REQ_SORT, 0, 0, 1));
      pending_reqs.push_back(mk(REQ_READ, 0, 3, 0));
      pending_reqs.push_back(mk(REQ_READ, 0, 4, 0));
      pending_reqs.push_back(mk(REQ_READ, 0, 8'hFF, 1));
      pending_reqs.push_back(mk(3'd6, 0, 0, 0));
      pending_reqs.push_back(mk(3'd7, EMPTY_ID, 8'hFF, 1));
      write_size(0);
      pending_reqs.push_back(mk(REQ_READ, 0, 0, 0));
      pending_reqs.push_back(mk(REQ_APPEND, 44, 0, 0));
      write_size(9'h1FF);
      pending_reqs.push_back(mk(REQ_READ, 0, 200, 0));

      // Random phases over several sizes, the extremes among them.
      sizes = '{9'd1, 9'd2, 9'd7, 9'd16, 9'd33, 9'd256};
      for (int ph = 0; ph < 16; ph++) begin
         int unsigned n;
         write_size((ph == 15) ? 9'd256 : sizes[$urandom_range(0, 4)]);
         n = clamp_size(mirror_size);
         for (int k = 0; k < 100; k++) begin
            tb_req_t r;
            r.req_type = pick_type();
            r.book_id = pick_id();
            r.slot_pos = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, n);
            r.descending = $urandom_range(0, 1);
            // Sorts on the full table are slow, so keep them rare there.
            if (n > 64 && r.req_type == REQ_SORT && $urandom_range(0, 7) != 0)
               r.req_type = REQ_LSRCH;
            pending_reqs.push_back(r);
         end
      end
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end
endmodule
